>>> rtl/mpl_pkg.sv
// Shared widths, constants and types of the mirrored piecewise-linear lookup.
package mpl_pkg;

  localparam int POS_W  = 17;  // Q1.16 positions and fractions
  localparam int VAL_W  = 32;  // Q16.16 values
  localparam int PIDX_W = 4;   // slot field of a write word
  localparam int CNT_W  = 5;   // point count register
  localparam int IDX_W  = 6;   // slot number carried in a token, covers the largest table

  localparam int DEF_MAX_POINTS = 16;
  localparam int DEF_LEN_BITS   = 12;

  // Shared divider: remainder width, quotient width and step counter width.
  localparam int DIV_W  = 18;
  localparam int QUO_W  = 32;
  localparam int STEP_W = 6;
  localparam int PROD_W = VAL_W + POS_W;

  localparam logic [STEP_W-1:0] FRAC_STEPS   = STEP_W'(POS_W);
  localparam logic [STEP_W-1:0] INTERP_STEPS = STEP_W'(QUO_W);

  localparam logic [POS_W-1:0] ONE_Q16     = POS_W'(65536);
  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(2);

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Search token that walks along the row of breakpoint cells.
  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] frac;
    logic             lo_ok;
    logic [IDX_W-1:0] lo_idx;
    logic [POS_W-1:0] lo_pos;
    logic [VAL_W-1:0] lo_val;
    logic             hi_ok;
    logic [IDX_W-1:0] hi_idx;
    logic [POS_W-1:0] hi_pos;
    logic [VAL_W-1:0] hi_val;
  } token_t;

  // Load word for the shared restoring divider.
  typedef struct packed {
    logic [DIV_W-1:0]  rem_init;
    logic [QUO_W-1:0]  low;
    logic [DIV_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

endpackage

>>> rtl/mpl_cell.sv
// One breakpoint cell: holds a slot of the table and refines the passing search token.
module mpl_cell import mpl_pkg::*; #(
  parameter int IDX   = 0,
  parameter int ACT_W = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [PIDX_W-1:0] wr_idx,
  input  logic [POS_W-1:0]  wr_pos,
  input  logic [VAL_W-1:0]  wr_val,
  input  logic [ACT_W-1:0]  cnt,
  input  token_t            tok_in,
  output token_t            tok_out
);

  logic [POS_W-1:0] pos;
  logic [VAL_W-1:0] val;
  logic             active;
  token_t           tok_next;

  always_ff @(posedge clk) begin
    if (wr_en && int'(wr_idx) == IDX) begin
      pos <= wr_pos;
      val <= wr_val;
    end
  end

  assign active = IDX < int'(cnt);

  // The lower bound is overwritten by every later slot at or below the fraction;
  // the upper bound follows each slot until one at or above the fraction is met.
  always_comb begin
    tok_next = tok_in;
    if (active) begin
      if (!tok_in.lo_ok || pos <= tok_in.frac) begin
        tok_next.lo_ok  = 1'b1;
        tok_next.lo_idx = IDX_W'(IDX);
        tok_next.lo_pos = pos;
        tok_next.lo_val = val;
      end
      if (!tok_in.hi_ok) begin
        tok_next.hi_ok  = pos >= tok_in.frac;
        tok_next.hi_idx = IDX_W'(IDX);
        tok_next.hi_pos = pos;
        tok_next.hi_val = val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

>>> rtl/mpl_div.sv
// Restoring divider, one quotient bit per cycle, shared by the fraction and the interpolation.
module mpl_div import mpl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  div_req_t         req,
  output logic             done,
  output logic [QUO_W-1:0] quot
);

  logic [DIV_W-1:0]  rem;
  logic [QUO_W-1:0]  shreg;
  logic [DIV_W-1:0]  divisor;
  logic [STEP_W-1:0] steps;
  logic [STEP_W-1:0] cnt;
  logic              busy;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              ge;

  assign trial = {rem, shreg[QUO_W-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= req.rem_init;
      shreg   <= req.low;
      divisor <= req.divisor;
      steps   <= req.steps;
      quot    <= '0;
    end else if (busy) begin
      rem   <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      shreg <= {shreg[QUO_W-2:0], 1'b0};
      quot  <= {quot[QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + STEP_W'(1);
        if (cnt == steps - STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/mirrored_piecewise_linear_lookup_core.sv
// Top level of the mirrored piecewise-linear lookup: control, arithmetic and the cell row.
//
// Input words carry an action bit. A write word stores one breakpoint (position, value) in
// the slot it names and answers with an all-zero result word. A query word mirrors its bin
// position about half the block length into a Q1.16 fraction, searches the breakpoint row
// and returns the linearly interpolated Q16.16 value together with that fraction.
// Both channels use valid/ready. The user must write the point count register through cfg_we
// and cfg_wdata only while the block is idle; the block itself does not enforce this.
// A write, or a query whose block length is one or less, goes from acceptance straight to
// the result; that query returns one in Q16.16 and a zero fraction. Any other query takes
// 17 steps of the shared divider for the fraction and passes each cell of the breakpoint row;
// if it lands on or beyond a breakpoint it ends there, else it runs the multiply states
// MUL0, MUL1 and MUL2 and 32 further divider steps. One word is in work at a time.
// The result sits in an output register, so the next word is taken while it waits; a
// stalled receiver holds the block only when a second result is ready behind it.
// Reset clears the control, empties the cell row and sets the point count to 2. The
// breakpoint table is not cleared and must be written before it is queried.
module mirrored_piecewise_linear_lookup_core import mpl_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS,
  parameter int LEN_BITS   = DEF_LEN_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CNT_W-1:0]    cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                action,
  input  logic [PIDX_W-1:0]   point_index,
  input  logic [POS_W-1:0]    point_position,
  input  logic [VAL_W-1:0]    point_value,
  input  logic [LEN_BITS-1:0] sample_pos,
  input  logic [LEN_BITS:0]   block_len,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [VAL_W-1:0]    interp_value,
  output logic [POS_W-1:0]    frequency_fraction
);

  localparam int ACT_W = $clog2(MAX_POINTS + 1);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_FRAC   = 4'd1;
  localparam logic [3:0] ST_SEARCH = 4'd2;
  localparam logic [3:0] ST_EVAL   = 4'd3;
  localparam logic [3:0] ST_MUL0   = 4'd4;
  localparam logic [3:0] ST_MUL1   = 4'd5;
  localparam logic [3:0] ST_MUL2   = 4'd6;
  localparam logic [3:0] ST_DIVS   = 4'd7;
  localparam logic [3:0] ST_DIVW   = 4'd8;
  localparam logic [3:0] ST_DONE   = 4'd9;

  logic [3:0]          state;
  logic [CNT_W-1:0]    point_count;
  logic [ACT_W-1:0]    cnt_eff;
  logic                accept;
  logic                out_free;

  logic [LEN_BITS-1:0] half;
  logic [LEN_BITS:0]   len_diff;
  logic [LEN_BITS-1:0] num;

  div_req_t            frac_req;
  div_req_t            interp_req;
  div_req_t            div_req;
  logic                div_start;
  logic                div_done;
  logic [QUO_W-1:0]    div_quot;
  logic [POS_W-1:0]    frac_sat;

  token_t              tok [MAX_POINTS+1];
  token_t              inj;
  token_t              found;

  logic [POS_W-1:0]    frac;
  logic [POS_W-1:0]    d0;
  logic [POS_W-1:0]    d1;
  logic                lo_le;
  logic                hi_le;
  logic [VAL_W-1:0]    mul_a;
  logic [POS_W-1:0]    mul_b;
  logic [PROD_W-1:0]   mul_p;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   acc;
  logic [VAL_W-1:0]    res_val;
  logic [POS_W-1:0]    res_frac;

  assign in_ready = state == ST_IDLE;
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= COUNT_RESET;
    end else if (cfg_we) begin
      point_count <= cfg_wdata;
    end
  end

  always_comb begin
    if (point_count == '0) begin
      cnt_eff = ACT_W'(1);
    end else if (int'(point_count) > MAX_POINTS) begin
      cnt_eff = ACT_W'(MAX_POINTS);
    end else begin
      cnt_eff = ACT_W'(point_count);
    end
  end

  // Mirror the bin position about half the block length; the result never exceeds half.
  assign half     = block_len[LEN_BITS:1];
  assign len_diff = block_len - {1'b0, sample_pos};

  always_comb begin
    if (sample_pos > half) begin
      num = (block_len >= {1'b0, sample_pos}) ? len_diff[LEN_BITS-1:0] : '0;
    end else begin
      num = sample_pos;
    end
  end

  // As the numerator is at most half, its top bits already sit below the divisor and only
  // seventeen quotient bits remain to be found.
  always_comb begin
    frac_req.rem_init = DIV_W'(num >> 1);
    frac_req.low      = {num[0], (QUO_W-1)'(0)};
    frac_req.divisor  = DIV_W'(half);
    frac_req.steps    = FRAC_STEPS;
  end

  // The weighted sum divided by the span is an average of two values, so it fits 32 bits.
  always_comb begin
    interp_req.rem_init = DIV_W'(acc[PROD_W-1:QUO_W]);
    interp_req.low      = acc[QUO_W-1:0];
    interp_req.divisor  = {1'b0, d0} + {1'b0, d1};
    interp_req.steps    = INTERP_STEPS;
  end

  assign div_req   = (state == ST_IDLE) ? frac_req : interp_req;
  assign div_start = (accept && action == ACT_QUERY && block_len > (LEN_BITS+1)'(1))
                     || state == ST_DIVS;

  mpl_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign frac_sat = (div_quot[POS_W-1:0] > ONE_Q16) ? ONE_Q16 : div_quot[POS_W-1:0];

  always_comb begin
    inj       = '0;
    inj.valid = state == ST_FRAC && div_done;
    inj.frac  = frac_sat;
  end

  assign tok[0] = inj;

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    mpl_cell #(
      .IDX   (i),
      .ACT_W (ACT_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .wr_en   (accept && action == ACT_WRITE),
      .wr_idx  (point_index),
      .wr_pos  (point_position),
      .wr_val  (point_value),
      .cnt     (cnt_eff),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  assign lo_le = frac <= found.lo_pos;
  assign hi_le = found.hi_pos <= frac;

  assign mul_a = (state == ST_MUL0) ? found.lo_val : found.hi_val;
  assign mul_b = (state == ST_MUL0) ? d1 : d0;
  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (action == ACT_WRITE) begin
            res_val  <= '0;
            res_frac <= '0;
          end else if (block_len <= (LEN_BITS+1)'(1)) begin
            res_val  <= VAL_W'(ONE_Q16);
            res_frac <= '0;
          end
        end
      end
      ST_FRAC: begin
        if (div_done) begin
          frac     <= frac_sat;
          res_frac <= frac_sat;
        end
      end
      ST_SEARCH: begin
        if (tok[MAX_POINTS].valid) begin
          found <= tok[MAX_POINTS];
        end
      end
      ST_EVAL: begin
        if (found.lo_idx == found.hi_idx || lo_le) begin
          res_val <= found.lo_val;
        end else if (hi_le) begin
          res_val <= found.hi_val;
        end
        d0 <= frac - found.lo_pos;
        d1 <= found.hi_pos - frac;
      end
      ST_MUL0: begin
        prod <= mul_p;
      end
      ST_MUL1: begin
        acc  <= prod;
        prod <= mul_p;
      end
      ST_MUL2: begin
        acc <= acc + prod;
      end
      ST_DIVW: begin
        if (div_done) begin
          res_val <= div_quot;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (action == ACT_WRITE || block_len <= (LEN_BITS+1)'(1)) begin
              state <= ST_DONE;
            end else begin
              state <= ST_FRAC;
            end
          end
        end
        ST_FRAC: begin
          if (div_done) begin
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (tok[MAX_POINTS].valid) begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (found.lo_idx == found.hi_idx || lo_le || hi_le) begin
            state <= ST_DONE;
          end else begin
            state <= ST_MUL0;
          end
        end
        ST_MUL0: state <= ST_MUL1;
        ST_MUL1: state <= ST_MUL2;
        ST_MUL2: state <= ST_DIVS;
        ST_DIVS: state <= ST_DIVW;
        ST_DIVW: begin
          if (div_done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      interp_value       <= res_val;
      frequency_fraction <= res_frac;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_token_in_search: assert property (@(posedge clk) disable iff (rst)
    tok[MAX_POINTS].valid |-> state == ST_SEARCH)
    else $error("search token left the cell row outside the search phase");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_FRAC || state == ST_DIVW))
    else $error("divider finished while no division was awaited");

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("a second word was taken in the cycle after acceptance");

  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> frequency_fraction <= ONE_Q16)
    else $error("fraction above one on the result channel");
`endif

endmodule

>>> sim/mirrored_piecewise_linear_lookup_core_test.sv
// Self-checking testbench of the mirrored piecewise-linear lookup core.
module mirrored_piecewise_linear_lookup_core_test;
  import mpl_pkg::*;

  localparam int MAX_POINTS  = DEF_MAX_POINTS;
  localparam int LEN_BITS    = DEF_LEN_BITS;
  localparam int WORD_TARGET = 1300;

  typedef struct {
    logic                action;
    logic [PIDX_W-1:0]   idx;
    logic [POS_W-1:0]    pos;
    logic [VAL_W-1:0]    val;
    logic [LEN_BITS-1:0] spos;
    logic [LEN_BITS:0]   blen;
  } lookup_word_t;

  typedef struct {
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] frac;
  } answer_t;

  typedef struct {
    lookup_word_t w;
    bit           known;
    answer_t      ans;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [CNT_W-1:0]    cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic                action;
  logic [PIDX_W-1:0]   point_index;
  logic [POS_W-1:0]    point_position;
  logic [VAL_W-1:0]    point_value;
  logic [LEN_BITS-1:0] sample_pos;
  logic [LEN_BITS:0]   block_len;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [VAL_W-1:0]    interp_value;
  logic [POS_W-1:0]    frequency_fraction;

  // Own copy of the breakpoint table and the point count.
  logic [POS_W-1:0] bp_pos [MAX_POINTS];
  logic [VAL_W-1:0] bp_val [MAX_POINTS];
  logic [CNT_W-1:0] point_count_reg;

  answer_t awaited_answers[$];
  int      fail_count;
  int      burst_left;
  bit      no_gaps;
  int      hold_left = 0;
  int      stall_mode = 0;

  mirrored_piecewise_linear_lookup_core i_dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .action             (action),
    .point_index        (point_index),
    .point_position     (point_position),
    .point_value        (point_value),
    .sample_pos         (sample_pos),
    .block_len          (block_len),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .interp_value       (interp_value),
    .frequency_fraction (frequency_fraction)
  );

  always #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [POS_W-1:0] mirror_fraction(logic [LEN_BITS-1:0] spos,
                                                       logic [LEN_BITS:0] blen);
    logic [LEN_BITS:0] half;
    logic [LEN_BITS:0] num;
    logic [63:0]       q;
    half = blen >> 1;
    if ({1'b0, spos} > half) begin
      num = (blen >= {1'b0, spos}) ? blen - {1'b0, spos} : '0;
    end else begin
      num = {1'b0, spos};
    end
    q = (64'(num) << 16) / 64'(half);
    return (q > 64'(ONE_Q16)) ? ONE_Q16 : POS_W'(q);
  endfunction

  function automatic logic [VAL_W-1:0] table_lookup(logic [POS_W-1:0] frac);
    int          cnt;
    int          lo;
    int          hi;
    int          i;
    bit          found;
    longint      d0;
    longint      d1;
    logic [63:0] num;
    cnt = int'(point_count_reg);
    if (cnt < 1) cnt = 1;
    if (cnt > MAX_POINTS) cnt = MAX_POINTS;
    lo = 0;
    hi = cnt - 1;
    found = 1'b0;
    for (i = cnt - 1; i >= 0; i--) begin
      if (!found && bp_pos[i] <= frac) begin
        lo = i;
        found = 1'b1;
      end
    end
    found = 1'b0;
    for (i = 0; i < cnt; i++) begin
      if (!found && bp_pos[i] >= frac) begin
        hi = i;
        found = 1'b1;
      end
    end
    d0 = longint'(frac) - longint'(bp_pos[lo]);
    d1 = longint'(bp_pos[hi]) - longint'(frac);
    if (hi == lo || d0 <= 0) return bp_val[lo];
    if (d1 <= 0) return bp_val[hi];
    num = 64'(bp_val[lo]) * 64'(d1) + 64'(bp_val[hi]) * 64'(d0);
    return VAL_W'(num / 64'(d0 + d1));
  endfunction

  // Works out the answer to one word and updates the table for writes.
  function automatic answer_t apply_word(lookup_word_t w);
    answer_t a;
    a.value = '0;
    a.frac  = '0;
    if (w.action == ACT_WRITE) begin
      bp_pos[w.idx] = w.pos;
      bp_val[w.idx] = w.val;
    end else if (w.blen <= 1) begin
      a.value = VAL_W'(ONE_Q16);
    end else begin
      a.frac  = mirror_fraction(w.spos, w.blen);
      a.value = table_lookup(a.frac);
    end
    return a;
  endfunction

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  function automatic lookup_word_t rand_word();
    lookup_word_t w;
    w.action = 1'($urandom);
    w.idx    = PIDX_W'($urandom);
    w.pos    = POS_W'($urandom);
    w.val    = rand_value();
    w.spos   = LEN_BITS'($urandom);
    w.blen   = (LEN_BITS+1)'($urandom);
    return w;
  endfunction

  function automatic lookup_word_t query_word();
    lookup_word_t w;
    int           r;
    int           len;
    w = rand_word();
    w.action = ACT_QUERY;
    r = $urandom_range(0, 99);
    if (r < 3) len = $urandom_range(0, 1);
    else if (r < 8) len = $urandom_range(4097, 8191);
    else if (r < 18) len = $urandom_range(2, 16);
    else len = $urandom_range(2, 4096);
    w.blen = (LEN_BITS+1)'(len);
    // Mostly keep the position inside the block; the rest may lie beyond it.
    if ($urandom_range(0, 4) != 0 && len >= 1 && len <= 4096) begin
      w.spos = LEN_BITS'($urandom_range(0, len - 1));
    end
    return w;
  endfunction

  function automatic dir_row_t row(logic act, int idx, int pos, logic [VAL_W-1:0] val,
                                   int spos, int blen, bit known,
                                   logic [VAL_W-1:0] ev, int ef);
    dir_row_t r;
    r.w.action    = act;
    r.w.idx       = PIDX_W'(idx);
    r.w.pos       = POS_W'(pos);
    r.w.val       = val;
    r.w.spos      = LEN_BITS'(spos);
    r.w.blen      = (LEN_BITS+1)'(blen);
    r.known       = known;
    r.ans.value   = ev;
    r.ans.frac    = POS_W'(ef);
    return r;
  endfunction

  task automatic send_word(input lookup_word_t w, input bit known, input answer_t typed);
    answer_t a;
    in_valid       <= 1'b1;
    action         <= w.action;
    point_index    <= w.idx;
    point_position <= w.pos;
    point_value    <= w.val;
    sample_pos     <= w.spos;
    block_len      <= w.blen;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    a = apply_word(w);
    awaited_answers.push_back(known ? typed : a);
  endtask

  // The sender works in bursts, with idle gaps between them unless no_gaps is set.
  task automatic pace();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!no_gaps) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_point_count(input logic [CNT_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    point_count_reg = v;
  endtask

  // Fills the slots in use, mostly with ascending positions.
  task automatic load_breakpoints(input int used);
    int           pos_list[$];
    int           i;
    bit           sorted_tbl;
    lookup_word_t w;
    answer_t      none;
    none.value = '0;
    none.frac  = '0;
    sorted_tbl = ($urandom_range(0, 9) < 7);
    for (i = 0; i < used; i++) begin
      pos_list.push_back(sorted_tbl ? $urandom_range(0, 65536) : $urandom_range(0, 131071));
    end
    if (sorted_tbl) begin
      pos_list.sort();
      if ($urandom_range(0, 1) == 1) begin
        pos_list[0] = 0;
        pos_list[used-1] = 65536;
      end
    end
    for (i = 0; i < used; i++) begin
      w = rand_word();
      w.action = ACT_WRITE;
      w.idx    = PIDX_W'(i);
      w.pos    = POS_W'(pos_list[i]);
      pace();
      send_word(w, 1'b0, none);
    end
  endtask

  // The receiver stalls on a pattern of its own, changing mode now and then.
  always @(posedge clk) begin
    if (hold_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      hold_left  <= $urandom_range(5, 40);
    end else begin
      hold_left <= hold_left - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    answer_t exp_a;
    if (!rst && out_valid && out_ready) begin
      if (awaited_answers.size() == 0) begin
        $error("result word with nothing awaited: interp_value %h, frequency_fraction %h",
               interp_value, frequency_fraction);
        fail_count++;
      end else begin
        exp_a = awaited_answers.pop_front();
        if (interp_value !== exp_a.value) begin
          $error("interp_value: expected %h, actual %h", exp_a.value, interp_value);
          fail_count++;
        end
        if (frequency_fraction !== exp_a.frac) begin
          $error("frequency_fraction: expected %h, actual %h", exp_a.frac,
                 frequency_fraction);
          fail_count++;
        end
      end
    end
  end

  initial begin
    dir_row_t     rows[$];
    int           i;
    int           sent;
    int           phase;
    int           cnt;
    int           used;
    int           n;
    lookup_word_t w;
    answer_t      none;

    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    in_valid       <= 1'b0;
    action         <= ACT_WRITE;
    point_index    <= '0;
    point_position <= '0;
    point_value    <= '0;
    sample_pos     <= '0;
    block_len      <= '0;
    none.value      = '0;
    none.frac       = '0;
    fail_count      = 0;
    burst_left      = 0;
    no_gaps         = 1'b0;
    point_count_reg = COUNT_RESET;
    for (i = 0; i < MAX_POINTS; i++) begin
      bp_pos[i] = '0;
      bp_val[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed words, run with the point count left at its reset value.
    //                 act        idx pos      val           spos  blen known exp value    frac
    rows.push_back(row(ACT_WRITE, 0,  0,       32'h0,        0,    0,   1, 32'h0,        0));
    rows.push_back(row(ACT_WRITE, 1,  65536,   32'hFFFFFFFF, 0,    0,   1, 32'h0,        0));
    rows.push_back(row(ACT_QUERY, 0,  0,       32'h0,        0,    1,   1, 32'h00010000, 0));
    rows.push_back(row(ACT_QUERY, 0,  0,       32'h0,        4095, 0,   1, 32'h00010000, 0));
    rows.push_back(row(ACT_QUERY, 0,  0,       32'h0,        0,    4096, 1, 32'h0,       0));
    rows.push_back(row(ACT_QUERY, 0,  0,       32'h0,        2048, 4096, 1, 32'hFFFFFFFF,
                       65536));
    rows.push_back(row(ACT_QUERY, 0,  0,       32'h0,        1024, 4096, 1, 32'h7FFFFFFF,
                       32768));
    rows.push_back(row(ACT_QUERY, 0,  0,       32'h0,        4095, 4096, 0, 32'h0,       0));
    rows.push_back(row(ACT_QUERY, 0,  0,       32'h0,        100,  8191, 0, 32'h0,       0));
    rows.push_back(row(ACT_QUERY, 0,  0,       32'h0,        4095, 10,  1, 32'h0,        0));
    rows.push_back(row(ACT_QUERY, 0,  0,       32'h0,        1,    3,   1, 32'hFFFFFFFF,
                       65536));
    rows.push_back(row(ACT_QUERY, 0,  0,       32'h0,        2,    2,   1, 32'h0,        0));
    rows.push_back(row(ACT_QUERY, 0,  0,       32'h0,        3000, 4096, 0, 32'h0,       0));
    rows.push_back(row(ACT_QUERY, 0,  0,       32'h0,        4095, 8191, 0, 32'h0,       0));
    // An unsorted table: the upper neighbour sits exactly on the fraction.
    rows.push_back(row(ACT_WRITE, 0,  32768,   32'h7,        0,    0,   1, 32'h0,        0));
    rows.push_back(row(ACT_WRITE, 1,  100,     32'h9,        0,    0,   1, 32'h0,        0));
    rows.push_back(row(ACT_QUERY, 0,  0,       32'h0,        1024, 4096, 1, 32'h7,       32768));
    rows.push_back(row(ACT_WRITE, 1,  131071,  32'h12345678, 0,    0,   1, 32'h0,        0));
    rows.push_back(row(ACT_QUERY, 0,  0,       32'h0,        2048, 4096, 0, 32'h0,       0));
    rows.push_back(row(ACT_QUERY, 0,  0,       32'h0,        0,    4096, 1, 32'h7,       0));
    rows.push_back(row(ACT_WRITE, 15, 131071,  32'hFFFFFFFF, 0,    0,   1, 32'h0,        0));
    for (i = 0; i < rows.size(); i++) begin
      pace();
      send_word(rows[i].w, rows[i].known, rows[i].ans);
    end

    sent  = 0;
    phase = 0;
    while (sent < WORD_TARGET) begin
      wait_drained();
      case (phase)
        0: cnt = 1;
        1: cnt = MAX_POINTS;
        2: cnt = 0;
        3: cnt = 31;
        4: cnt = 2;
        default: begin
          cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
        end
      endcase
      set_point_count(CNT_W'(cnt));
      used = (cnt < 1) ? 1 : ((cnt > MAX_POINTS) ? MAX_POINTS : cnt);
      no_gaps = ($urandom_range(0, 3) == 0);
      load_breakpoints(used);
      n = $urandom_range(60, 110);
      repeat (n) begin
        if ($urandom_range(0, 59) == 0) wait_drained();
        // Now and then a stray write disturbs the table.
        if ($urandom_range(0, 9) == 0) begin
          w = rand_word();
          w.action = ACT_WRITE;
        end else begin
          w = query_word();
        end
        pace();
        send_word(w, 1'b0, none);
      end
      sent += used + n;
      phase++;
    end

    wait_drained();
    repeat (80) @(posedge clk);
    if (fail_count == 0 && awaited_answers.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
